### hw/rtl/pa_pkg.sv
`timescale 1ns / 1ps
package pa_pkg;

    // Topology codes held in the mode register
    localparam logic [3:0] MODE_TRIS       = 4'd0;
    localparam logic [3:0] MODE_TRI_STRIP  = 4'd1;
    localparam logic [3:0] MODE_TRI_FAN    = 4'd2;
    localparam logic [3:0] MODE_LINES      = 4'd3;
    localparam logic [3:0] MODE_LINE_STRIP = 4'd4;
    localparam logic [3:0] MODE_LINE_LOOP  = 4'd5;
    localparam logic [3:0] MODE_POINTS     = 4'd6;
    localparam logic [3:0] MODE_QUADS      = 4'd7;
    localparam logic [3:0] MODE_QUAD_STRIP = 4'd8;
    localparam logic [3:0] MODE_POLYGON    = 4'd9;

    // Primitive kinds on the result side
    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_TRI   = 2'd2;

    localparam int VERT_W = 32;

    // Result queue depth; must be at least two
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [VERT_W-1:0] vertex_index;
        logic              first_in_draw;
        logic              last_in_draw;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        prim_kind;
        logic [VERT_W-1:0] vert_a;
        logic [VERT_W-1:0] vert_b;
        logic [VERT_W-1:0] vert_c;
        logic              last_of_item;
    } out_word_t;

    // Up to two primitives produced by one accepted index
    typedef struct packed {
        logic      first_valid;
        logic      second_valid;
        out_word_t first;
        out_word_t second;
    } pa_emit_t;

endpackage

### hw/rtl/primitive_assembler.sv
`timescale 1ns / 1ps
// Primitive assembler: takes one vertex index word per cycle while in_ready
// is high and groups the stream into points, lines or triangles by the
// topology in the mode register. An accepted index may produce zero, one or
// two primitive words, which enter a small result queue in that same cycle;
// the queue drains one word per cycle while out_ready is high. in_ready stays
// high while the queue has room for two words, so with a consumer that takes
// every word the block accepts one index per clock; only a line loop closing
// or quads and quad strips emitting pairs faster than the consumer drains can
// make it pause. Results for a given index are registered in the queue before
// they appear on the output. Write the mode register only while idle.
module primitive_assembler
    import pa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_data
);

    logic     in_accept;
    logic     has_room;
    pa_emit_t emit;

    assign in_ready  = has_room;
    assign in_accept = in_valid && has_room;

    // Assemble primitives from the index history
    pa_assemble u_assemble (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_word   (in_data),
        .emit      (emit)
    );

    // Queue result words toward the consumer
    pa_out_queue #(
        .DEPTH (DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        emit.second_valid |-> emit.first_valid && emit.second.last_of_item)
        else $error("second primitive without first");

    a_emit_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |-> !emit.first_valid && !emit.second_valid)
        else $error("primitive emitted without an accepted index");

    a_pair_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit.first_valid |-> (emit.first.last_of_item == !emit.second_valid))
        else $error("last_of_item misplaced");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.prim_kind == KIND_POINT || out_data.prim_kind == KIND_LINE
                       || out_data.prim_kind == KIND_TRI))
        else $error("illegal primitive kind on output");
`endif

endmodule

### hw/rtl/pa_assemble.sv
`timescale 1ns / 1ps
module pa_assemble
    import pa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_data,
    input  logic       in_accept,
    input  in_word_t   in_word,
    output pa_emit_t   emit
);

    logic [3:0]        prim_mode_reg;
    logic [VERT_W-1:0] hub_reg;
    logic [VERT_W-1:0] hist0_reg;
    logic [VERT_W-1:0] hist1_reg;
    logic [VERT_W-1:0] hist2_reg;
    logic [VERT_W-1:0] pos_reg;
    logic [1:0]        mod3_reg;

    logic [VERT_W-1:0] hub_next;
    logic [VERT_W-1:0] pos_next;
    logic [1:0]        mod3_next;

    logic [VERT_W-1:0] v;
    logic [VERT_W-1:0] p;
    logic [1:0]        p_mod3;
    logic              p_zero;
    logic              p_ge2;
    logic [VERT_W-1:0] h0;
    logic [VERT_W-1:0] h1;
    logic [VERT_W-1:0] h2;
    logic              last;
    logic              fire_a;
    logic              fire_b;
    out_word_t         prim_a;
    out_word_t         prim_b;

    // Current position: a first flag restarts the draw
    always_comb
    begin
        v      = in_word.vertex_index;
        last   = in_word.last_in_draw;
        p      = in_word.first_in_draw ? '0 : pos_reg;
        p_mod3 = in_word.first_in_draw ? 2'd0 : mod3_reg;
        p_zero = (p == '0);
        p_ge2  = (p[VERT_W-1:1] != '0);
        hub_next = p_zero ? v : hub_reg;
        h0 = p_zero ? '0 : hist0_reg;
        h1 = p_zero ? '0 : hist1_reg;
        h2 = p_zero ? '0 : hist2_reg;
    end

    // Advance position and its residue mod 3; a 32-bit wrap restarts the residue
    always_comb
    begin
        pos_next = last ? '0 : p + 1'b1;
        if (last || (p == '1))
        begin
            mod3_next = 2'd0;
        end
        else
        begin
            mod3_next = (p_mod3 == 2'd2) ? 2'd0 : p_mod3 + 2'd1;
        end
    end

    // Pick primitives for the configured topology
    always_comb
    begin
        fire_a = 1'b0;
        fire_b = 1'b0;
        prim_a = '0;
        prim_b = '0;
        case (prim_mode_reg)
            MODE_TRIS:
            begin
                fire_a = (p_mod3 == 2'd2);
                prim_a.prim_kind = KIND_TRI;
                prim_a.vert_a = h1;
                prim_a.vert_b = h0;
                prim_a.vert_c = v;
            end
            MODE_TRI_STRIP:
            begin
                fire_a = p_ge2;
                prim_a.prim_kind = KIND_TRI;
                prim_a.vert_a = p[0] ? h0 : h1;
                prim_a.vert_b = p[0] ? h1 : h0;
                prim_a.vert_c = v;
            end
            MODE_TRI_FAN, MODE_POLYGON:
            begin
                fire_a = p_ge2;
                prim_a.prim_kind = KIND_TRI;
                prim_a.vert_a = hub_next;
                prim_a.vert_b = h0;
                prim_a.vert_c = v;
            end
            MODE_LINES:
            begin
                fire_a = p[0];
                prim_a.prim_kind = KIND_LINE;
                prim_a.vert_a = h0;
                prim_a.vert_b = v;
            end
            MODE_LINE_STRIP:
            begin
                fire_a = !p_zero;
                prim_a.prim_kind = KIND_LINE;
                prim_a.vert_a = h0;
                prim_a.vert_b = v;
            end
            MODE_LINE_LOOP:
            begin
                fire_a = !p_zero;
                fire_b = !p_zero && last;
                prim_a.prim_kind = KIND_LINE;
                prim_a.vert_a = h0;
                prim_a.vert_b = v;
                prim_b.prim_kind = KIND_LINE;
                prim_b.vert_a = v;
                prim_b.vert_b = hub_next;
            end
            MODE_POINTS:
            begin
                fire_a = 1'b1;
                prim_a.prim_kind = KIND_POINT;
                prim_a.vert_a = v;
            end
            MODE_QUADS:
            begin
                fire_a = (p[1:0] == 2'd3);
                fire_b = fire_a;
                prim_a.prim_kind = KIND_TRI;
                prim_a.vert_a = h2;
                prim_a.vert_b = h1;
                prim_a.vert_c = v;
                prim_b.prim_kind = KIND_TRI;
                prim_b.vert_a = h1;
                prim_b.vert_b = h0;
                prim_b.vert_c = v;
            end
            MODE_QUAD_STRIP:
            begin
                // odd and not position one means at least three
                fire_a = p[0] && p_ge2;
                fire_b = fire_a;
                prim_a.prim_kind = KIND_TRI;
                prim_a.vert_a = h2;
                prim_a.vert_b = h1;
                prim_a.vert_c = v;
                prim_b.prim_kind = KIND_TRI;
                prim_b.vert_a = h0;
                prim_b.vert_b = h2;
                prim_b.vert_c = v;
            end
            default:
            begin
                fire_a = 1'b0;
                fire_b = 1'b0;
            end
        endcase
        prim_a.last_of_item = !fire_b;
        prim_b.last_of_item = 1'b1;
    end

    // Drive emitted words only on an accepted index
    always_comb
    begin
        emit.first_valid  = in_accept && fire_a;
        emit.second_valid = in_accept && fire_b;
        emit.first        = prim_a;
        emit.second       = prim_b;
    end

    // Hold the topology register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_mode_reg <= MODE_TRIS;
        end
        else if (cfg_we)
        begin
            prim_mode_reg <= cfg_data;
        end
    end

    // Shift history and advance position on each accepted index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hub_reg   <= '0;
            hist0_reg <= '0;
            hist1_reg <= '0;
            hist2_reg <= '0;
            pos_reg   <= '0;
            mod3_reg  <= 2'd0;
        end
        else if (in_accept)
        begin
            hub_reg   <= hub_next;
            hist0_reg <= v;
            hist1_reg <= h0;
            hist2_reg <= h1;
            pos_reg   <= pos_next;
            mod3_reg  <= mod3_next;
        end
    end

endmodule

### hw/rtl/pa_out_queue.sv
`timescale 1ns / 1ps
module pa_out_queue
    import pa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  pa_emit_t  emit,
    output logic      has_room,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    out_word_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [PTR_W-1:0] wr_ptr_plus2;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;
    logic [CNT_W-1:0] push_n;

    // Wrap pointers at the queue depth
    always_comb
    begin
        wr_ptr_plus1 = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        wr_ptr_plus2 = (wr_ptr_plus1 == PTR_LAST) ? '0 : wr_ptr_plus1 + 1'b1;
        pop          = out_valid && out_ready;
        push_n       = CNT_W'(emit.first_valid) + CNT_W'(emit.second_valid);
        if (emit.second_valid)
        begin
            wr_ptr_next = wr_ptr_plus2;
        end
        else if (emit.first_valid)
        begin
            wr_ptr_next = wr_ptr_plus1;
        end
        else
        begin
            wr_ptr_next = wr_ptr_reg;
        end
        rd_ptr_next = pop ? ((rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + push_n - CNT_W'(pop);
    end

    // Accept a new index only with room for two words
    assign has_room  = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (emit.first_valid)
        begin
            mem[wr_ptr_reg] <= emit.first;
        end
        if (emit.second_valid)
        begin
            mem[wr_ptr_plus1] <= emit.second;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### test/pa_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the primitive assembler, keeps its own copy of the
// assembly state, predicts the primitive words and compares them in order.
module pa_checker
    import pa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [3:0] cfg_data,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_data,
    output int        mismatches,
    output int        awaiting
);

    logic [3:0]        topology;
    logic [VERT_W-1:0] hub;
    logic [VERT_W-1:0] recent [3];
    logic [VERT_W-1:0] position;
    out_word_t         expected_prims [$];
    out_word_t         want;
    int                fault_total;

    function automatic out_word_t form_prim(input logic [1:0] kind,
                                            input logic [VERT_W-1:0] a,
                                            input logic [VERT_W-1:0] b,
                                            input logic [VERT_W-1:0] c);
        out_word_t w;
        w.prim_kind    = kind;
        w.vert_a       = a;
        w.vert_b       = b;
        w.vert_c       = c;
        w.last_of_item = 1'b0;
        return w;
    endfunction

    // Advance the assembly state by one index and queue what it completes
    task automatic assemble(input in_word_t w);
        logic [VERT_W-1:0] v;
        logic [VERT_W-1:0] p;
        logic [VERT_W-1:0] h0;
        logic [VERT_W-1:0] h1;
        logic [VERT_W-1:0] h2;
        out_word_t         made [2];
        int                n;
        v = w.vertex_index;
        if (w.first_in_draw)
            position = '0;
        p = position;
        // A new draw: this index becomes the hub, history starts clean
        if (p == 0)
        begin
            hub       = v;
            recent[0] = '0;
            recent[1] = '0;
            recent[2] = '0;
        end
        h0 = recent[0];
        h1 = recent[1];
        h2 = recent[2];
        n  = 0;
        case (topology)
            MODE_TRIS:
                if (p % 3 == 2)
                begin
                    made[n] = form_prim(KIND_TRI, h1, h0, v);
                    n++;
                end
            MODE_TRI_STRIP:
                if (p >= 2)
                begin
                    // Odd positions swap the winding
                    made[n] = p[0] ? form_prim(KIND_TRI, h0, h1, v)
                                   : form_prim(KIND_TRI, h1, h0, v);
                    n++;
                end
            MODE_TRI_FAN, MODE_POLYGON:
                if (p >= 2)
                begin
                    made[n] = form_prim(KIND_TRI, hub, h0, v);
                    n++;
                end
            MODE_LINES:
                if (p[0])
                begin
                    made[n] = form_prim(KIND_LINE, h0, v, '0);
                    n++;
                end
            MODE_LINE_STRIP:
                if (p != 0)
                begin
                    made[n] = form_prim(KIND_LINE, h0, v, '0);
                    n++;
                end
            MODE_LINE_LOOP:
                if (p != 0)
                begin
                    made[n] = form_prim(KIND_LINE, h0, v, '0);
                    n++;
                    // Close the loop back to the hub at the end of the draw
                    if (w.last_in_draw)
                    begin
                        made[n] = form_prim(KIND_LINE, v, hub, '0);
                        n++;
                    end
                end
            MODE_POINTS:
            begin
                made[n] = form_prim(KIND_POINT, v, '0, '0);
                n++;
            end
            MODE_QUADS:
                if (p[1:0] == 2'b11)
                begin
                    made[0] = form_prim(KIND_TRI, h2, h1, v);
                    made[1] = form_prim(KIND_TRI, h1, h0, v);
                    n = 2;
                end
            MODE_QUAD_STRIP:
                if (p >= 3 && p[0])
                begin
                    made[0] = form_prim(KIND_TRI, h2, h1, v);
                    made[1] = form_prim(KIND_TRI, h0, h2, v);
                    n = 2;
                end
            default:
                ;
        endcase
        if (n > 0)
            made[n-1].last_of_item = 1'b1;
        for (int i = 0; i < n; i++)
            expected_prims.push_back(made[i]);
        recent[2] = h1;
        recent[1] = h0;
        recent[0] = v;
        position  = w.last_in_draw ? '0 : p + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology    = MODE_TRIS;
            hub         = '0;
            recent[0]   = '0;
            recent[1]   = '0;
            recent[2]   = '0;
            position    = '0;
            fault_total = 0;
            expected_prims.delete();
            mismatches <= 0;
            awaiting   <= 0;
        end
        else
        begin
            // Compare each delivered word with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_prims.size() == 0)
                begin
                    $error("primitive word with none expected: kind %0d a %h b %h c %h",
                           out_data.prim_kind, out_data.vert_a, out_data.vert_b,
                           out_data.vert_c);
                    fault_total++;
                end
                else
                begin
                    want = expected_prims.pop_front();
                    if (out_data.prim_kind !== want.prim_kind)
                    begin
                        $error("prim_kind: expected %0d, got %0d",
                               want.prim_kind, out_data.prim_kind);
                        fault_total++;
                    end
                    if (out_data.vert_a !== want.vert_a)
                    begin
                        $error("vert_a: expected %h, got %h", want.vert_a, out_data.vert_a);
                        fault_total++;
                    end
                    if (out_data.vert_b !== want.vert_b)
                    begin
                        $error("vert_b: expected %h, got %h", want.vert_b, out_data.vert_b);
                        fault_total++;
                    end
                    if (out_data.vert_c !== want.vert_c)
                    begin
                        $error("vert_c: expected %h, got %h", want.vert_c, out_data.vert_c);
                        fault_total++;
                    end
                    if (out_data.last_of_item !== want.last_of_item)
                    begin
                        $error("last_of_item: expected %0d, got %0d",
                               want.last_of_item, out_data.last_of_item);
                        fault_total++;
                    end
                end
            end
            if (in_valid && in_ready)
                assemble(in_data);
            if (cfg_we)
                topology = cfg_data;
            awaiting   <= expected_prims.size();
            mismatches <= fault_total;
        end
    end

endmodule

### test/tb_primitive_assembler.sv
`timescale 1ns / 1ps
// Drives index words and mode writes into the primitive assembler and gives
// the verdict from the checker's counts.
module tb_primitive_assembler;
    import pa_pkg::*;

    localparam int         RANDOM_ITEMS  = 1900;
    localparam int         CYCLE_LIMIT   = 600000;
    localparam logic [3:0] MODE_SPARE_LO = 4'd10;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    // Receiver stall styles
    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_BURSTY   = 3;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [3:0] cfg_data  = '0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_word_t   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_word_t  out_data;

    int mismatches;
    int awaiting;
    int cycles      = 0;
    int burst_left  = 0;
    int stall_style = STALL_NONE;
    int stall_left  = 0;
    int stall_tick  = 0;
    int sent        = 0;
    bit calm        = 1'b1;

    always #2 clk = ~clk;

    primitive_assembler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    pa_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL primitive_assembler");
            $finish;
        end
    end

    // Receiver stall pattern
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        case (stall_style)
            STALL_RANDOM:
                out_ready <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC:
                out_ready <= ((stall_tick % 5) < 2);
            STALL_BURSTY:
                if (stall_left > 0)
                begin
                    stall_left <= stall_left - 1;
                    out_ready  <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    stall_left <= $urandom_range(1, 8);
                    out_ready  <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            default:
                out_ready <= 1'b1;
        endcase
    end

    function automatic logic [VERT_W-1:0] pick_vertex();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return VERT_W'($urandom_range(0, 15));
            default: return VERT_W'($urandom);
        endcase
    endfunction

    // Offer one word, in bursts with random gaps between them unless the phase is calm
    task automatic send_word(input logic [VERT_W-1:0] v, input logic first,
                             input logic last);
        in_word_t w;
        int       gap;
        w.vertex_index  = v;
        w.first_in_draw = first;
        w.last_in_draw  = last;
        if (burst_left == 0)
        begin
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Write the mode register once every pending primitive has come out
    task automatic set_mode(input logic [3:0] m);
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One draw; most are well formed, some drop a flag or scramble them
    task automatic send_draw();
        int len;
        int shape;
        bit f;
        bit l;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                            : $urandom_range(1, 14);
        shape = $urandom_range(0, 9);
        for (int i = 0; i < len && sent < RANDOM_ITEMS; i++)
        begin
            f = (i == 0);
            l = (i == len - 1);
            if (shape == 7)
                f = 1'b0;
            else if (shape == 8)
                l = 1'b0;
            else if (shape == 9)
            begin
                f = ($urandom_range(0, 4) == 0);
                l = ($urandom_range(0, 4) == 0);
            end
            send_word(pick_vertex(), f, l);
            sent++;
        end
    endtask

    initial
    begin
        logic [3:0] m;
        int         phase_end;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-index draws, closing line, dropped first flag
        set_mode(MODE_POINTS);
        send_word('1, 1'b1, 1'b1);
        send_word('0, 1'b1, 1'b1);
        set_mode(MODE_LINE_LOOP);
        send_word('1, 1'b1, 1'b0);
        send_word('0, 1'b0, 1'b0);
        send_word(32'h8000_0001, 1'b0, 1'b1);
        send_word(32'h0000_0007, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0, 1'b1);
        set_mode(MODE_TRIS);
        send_word(32'h0000_0005, 1'b1, 1'b1);
        // Switch topology in the middle of a draw
        set_mode(MODE_TRI_STRIP);
        send_word(32'h0000_0010, 1'b1, 1'b0);
        send_word(32'h0000_0011, 1'b0, 1'b0);
        set_mode(MODE_QUADS);
        send_word(32'h0000_0012, 1'b0, 1'b0);
        send_word(32'h0000_0013, 1'b0, 1'b1);
        set_mode(MODE_QUAD_STRIP);
        send_word(32'h0000_0020, 1'b1, 1'b0);
        send_word(32'h0000_0021, 1'b0, 1'b0);
        send_word(32'h0000_0022, 1'b0, 1'b0);
        send_word(32'h0000_0023, 1'b0, 1'b1);
        set_mode(MODE_SPARE_HI);
        send_word(32'h0000_0030, 1'b1, 1'b0);
        send_word(32'h0000_0031, 1'b0, 1'b1);

        // Random phases, each with its own topology and flow pattern
        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++)
        begin
            if (phase < 16)
                m = phase[3:0];
            else if ($urandom_range(0, 4) == 0)
                m = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            else
                m = 4'($urandom_range(MODE_TRIS, MODE_POLYGON));
            set_mode(m);
            calm = (phase % 4 == 3);
            stall_style <= calm ? STALL_NONE : $urandom_range(STALL_RANDOM, STALL_BURSTY);
            phase_end = sent + $urandom_range(60, 130);
            while (sent < phase_end && sent < RANDOM_ITEMS)
                send_draw();
        end

        // Drain and give the verdict
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("PASS primitive_assembler");
        else
            $display("FAIL primitive_assembler");
        $finish;
    end

endmodule
